FILE: src/ced_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ced_pkg;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_F      = 8'h66;

   localparam logic [7:0] CODE_LF = 8'd10;
   localparam logic [7:0] CODE_HT = 8'd9;
   localparam logic [7:0] CODE_BS = 8'd8;
   localparam logic [7:0] CODE_CR = 8'd13;
   localparam logic [7:0] CODE_FF = 8'd12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_OCT1 = 2'd2,
      MODE_OCT2 = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } write_type;

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_N:  r = CODE_LF;
         CHAR_T:  r = CODE_HT;
         CHAR_B:  r = CODE_BS;
         CHAR_R:  r = CODE_CR;
         CHAR_F:  r = CODE_FF;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/ced_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ced_decode
   import ced_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_char,
   input  wire logic       in_end,
   input  wire logic       room,
   output write_type       wr
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       end_ff;
   mode_type   mode_ff, mode_in;
   logic [5:0] accum_ff, accum_in;

   logic       proceed;
   logic       take;
   logic       is_oct;
   logic       is_bs;
   logic [2:0] digit;
   logic [1:0] n;
   result_type r0, r1, plain;

   assign proceed  = valid_ff && room;
   assign in_ready = !valid_ff || room;
   assign take     = in_valid && in_ready;
   assign valid_in = take ? 1'b1 : (proceed ? 1'b0 : valid_ff);

   assign is_oct = char_ff inside {[CHAR_ZERO:CHAR_SEVEN]};
   assign is_bs  = (char_ff == CHAR_BSLASH);
   assign digit  = char_ff[2:0];
   assign plain  = '{data: char_ff, term: 1'b0, last: 1'b0};

   always_comb begin
      n        = 2'd0;
      r0       = '0;
      r1       = '0;
      mode_in  = mode_ff;
      accum_in = accum_ff;
      if (end_ff) begin
         if (mode_ff == MODE_OCT1 || mode_ff == MODE_OCT2) begin
            r0 = '{data: {2'b00, accum_ff}, term: 1'b0, last: 1'b0};
            r1 = '{data: 8'd0, term: 1'b1, last: 1'b0};
            n  = 2'd2;
         end else begin
            r0 = '{data: 8'd0, term: 1'b1, last: 1'b0};
            n  = 2'd1;
         end
         mode_in  = MODE_TEXT;
         accum_in = '0;
      end else begin
         case (mode_ff)
            MODE_TEXT: begin
               if (is_bs) begin
                  mode_in = MODE_ESC;
               end else begin
                  r0 = plain;
                  n  = 2'd1;
               end
            end
            MODE_ESC: begin
               if (is_oct) begin
                  accum_in = {3'b000, digit};
                  mode_in  = MODE_OCT1;
               end else begin
                  r0      = '{data: map_escape(char_ff), term: 1'b0, last: 1'b0};
                  n       = 2'd1;
                  mode_in = MODE_TEXT;
               end
            end
            MODE_OCT1, MODE_OCT2: begin
               if (is_oct && mode_ff == MODE_OCT1) begin
                  accum_in = {accum_ff[2:0], digit};
                  mode_in  = MODE_OCT2;
               end else if (is_oct) begin
                  r0       = '{data: {accum_ff[4:0], digit}, term: 1'b0, last: 1'b0};
                  n        = 2'd1;
                  accum_in = '0;
                  mode_in  = MODE_TEXT;
               end else begin
                  r0       = '{data: {2'b00, accum_ff}, term: 1'b0, last: 1'b0};
                  accum_in = '0;
                  if (is_bs) begin
                     n       = 2'd1;
                     mode_in = MODE_ESC;
                  end else begin
                     r1      = plain;
                     n       = 2'd2;
                     mode_in = MODE_TEXT;
                  end
               end
            end
            default: begin
               mode_in = MODE_TEXT;
            end
         endcase
      end
      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end
   end

   assign wr = '{count: proceed ? n : 2'd0, res0: r0, res1: r1};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff  <= MODE_TEXT;
         accum_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (proceed) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= in_char;
         end_ff  <= in_end;
      end
   end

endmodule

`default_nettype wire

FILE: src/ced_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ced_queue
   import ced_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  write_type       wr,
   output logic            room,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_res
);

   result_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic [QUEUE_AW-1:0]   wptr_next;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign wptr_next = wptr_ff + QUEUE_AW'(1);
   assign wptr_in   = wptr_ff + QUEUE_AW'(wr.count);
   assign rptr_in   = rptr_ff + QUEUE_AW'(pop);
   assign count_in  = count_ff + QUEUE_CW'(wr.count) - QUEUE_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.count != 2'd0) begin
         mem_ff[wptr_ff] <= wr.res0;
      end
      if (wr.count == 2'd2) begin
         mem_ff[wptr_next] <= wr.res1;
      end
   end

endmodule

`default_nettype wire

FILE: src/c_escape_sequence_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted word is held in the input stage, and its results are written
// into the result queue, which drives rsp_. Throughput: one word per cycle;
// a word may yield two results, and req_tready drops while a word is held in
// the input stage and the 4-entry result queue has under 2 free slots.
// Reset: synchronous; clears the decode mode, octal accumulator, input stage
// and result queue.
module c_escape_sequence_decoder
   import ced_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_in
   input  wire logic       req_tlast,   // end_in
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] char_out
   output logic            rsp_tuser,   // is_terminator
   output logic            rsp_tlast    // last
);

   write_type  wr;
   logic       room;
   result_type res;

   ced_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .in_end   (req_tlast),
      .room     (room),
      .wr       (wr)
   );

   ced_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   assign rsp_tdata = res.data;
   assign rsp_tuser = res.term;
   assign rsp_tlast = res.last;

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (wr.count != 2'd0) |-> room)
      else $error("result write without queue room");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (wr.count == 2'd2) |-> (wr.res1.last && !wr.res0.last && !wr.res0.term))
      else $error("bad last marking on result pair");

   a_term_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("terminator result malformed");

   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_tready)
      else $error("input not ready after reset");

endmodule

`default_nettype wire

FILE: verif/tb_c_escape_sequence_decoder.sv
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder;
   import ced_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 900;
   localparam int SQUEEZE_AT   = 150;
   localparam int SQUEEZE_LEN  = 300;
   localparam int DRAIN_CYCLES = 12;

   class escape_tracker;
      mode_type   mode;
      logic [5:0] accum;
      result_type due[$];
      int         mismatches;
      int         checked;
      int         terminators;

      function new();
         mode        = MODE_TEXT;
         accum       = '0;
         mismatches  = 0;
         checked     = 0;
         terminators = 0;
      endfunction

      function void push(logic [7:0] d, logic t);
         result_type r;
         r.data = d;
         r.term = t;
         r.last = 1'b0;
         due.push_back(r);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_SEVEN;
      endfunction

      // ordinary text byte: emit it, or open an escape on backslash
      function void text_byte(logic [7:0] c);
         if (c == CHAR_BSLASH) begin
            mode = MODE_ESC;
         end else begin
            mode = MODE_TEXT;
            push(c, 1'b0);
         end
      endfunction

      function void note_word(logic [7:0] c, logic e);
         int         first;
         logic [2:0] digit;
         logic [7:0] code;
         first = due.size();
         digit = 3'(c - CHAR_ZERO);
         if (e) begin
            if (mode == MODE_OCT1 || mode == MODE_OCT2)
               push({2'b00, accum}, 1'b0);
            push(8'h00, 1'b1);
            mode  = MODE_TEXT;
            accum = '0;
         end else begin
            case (mode)
               MODE_TEXT: text_byte(c);
               MODE_ESC: begin
                  if (is_digit(c)) begin
                     accum = {3'b000, digit};
                     mode  = MODE_OCT1;
                  end else begin
                     case (c)
                        CHAR_N:  code = CODE_LF;
                        CHAR_T:  code = CODE_HT;
                        CHAR_B:  code = CODE_BS;
                        CHAR_R:  code = CODE_CR;
                        CHAR_F:  code = CODE_FF;
                        default: code = c;
                     endcase
                     push(code, 1'b0);
                     mode = MODE_TEXT;
                  end
               end
               MODE_OCT1: begin
                  if (is_digit(c)) begin
                     accum = {accum[2:0], digit};
                     mode  = MODE_OCT2;
                  end else begin
                     push({2'b00, accum}, 1'b0);
                     accum = '0;
                     text_byte(c);
                  end
               end
               default: begin
                  if (is_digit(c)) begin
                     // third digit: value wraps to 8 bits
                     push({accum[4:0], digit}, 1'b0);
                     mode = MODE_TEXT;
                  end else begin
                     push({2'b00, accum}, 1'b0);
                     text_byte(c);
                  end
                  accum = '0;
               end
            endcase
         end
         if (due.size() > first)
            due[due.size() - 1].last = 1'b1;
      endfunction

      function void check_word(logic [7:0] d, logic t, logic l);
         result_type x;
         checked++;
         if (t)
            terminators++;
         if (due.size() == 0) begin
            $error("unexpected word: char_out=%0h is_terminator=%0b last=%0b", d, t, l);
            mismatches++;
            return;
         end
         x = due.pop_front();
         if (d !== x.data) begin
            $error("char_out: expected %0h, got %0h", x.data, d);
            mismatches++;
         end
         if (t !== x.term) begin
            $error("is_terminator: expected %0b, got %0b", x.term, t);
            mismatches++;
         end
         if (l !== x.last) begin
            $error("last: expected %0b, got %0b", x.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_in
   logic       req_tlast = 1'b0;    // end_in
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] char_out
   logic       rsp_tuser;           // is_terminator
   logic       rsp_tlast;           // last

   escape_tracker sb = new();
   int words_sent = 0;
   int cycles = 0;
   bit draining = 1'b0;
   bit send_steady = 1'b0;
   int send_phase = 40;

   c_escape_sequence_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_word(logic [7:0] c, logic e);
      int gap;
      gap = 0;
      if (--send_phase <= 0) begin
         send_steady = ~send_steady;
         send_phase  = $urandom_range(20, 120);
      end
      if (!send_steady && $urandom_range(0, 2) == 0)
         gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= e;
      do @(posedge clock); while (!req_tready);
      sb.note_word(c, e);
      words_sent++;
   endtask

   task automatic send_string(string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], 1'b0);
   endtask

   task automatic send_token();
      int         r;
      int         n;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      c = 8'($urandom_range(0, 255));
      if (r < 35) begin
         if (c == CHAR_BSLASH)
            c = CHAR_SEVEN;
         send_word(c, 1'b0);
      end else if (r < 50) begin
         send_word(CHAR_BSLASH, 1'b0);
         case ($urandom_range(0, 4))
            0:       c = CHAR_N;
            1:       c = CHAR_T;
            2:       c = CHAR_B;
            3:       c = CHAR_R;
            default: c = CHAR_F;
         endcase
         send_word(c, 1'b0);
      end else if (r < 75) begin
         send_word(CHAR_BSLASH, 1'b0);
         n = $urandom_range(1, 3);
         repeat (n) send_word(CHAR_ZERO + 8'($urandom_range(0, 7)), 1'b0);
      end else if (r < 85) begin
         send_word(CHAR_BSLASH, 1'b0);
         send_word(c, 1'b0);
      end else if (r < 92) begin
         send_word(c, 1'b1);
      end else begin
         send_word(c, $urandom_range(0, 9) == 0);
      end
   endtask

   // result side: random stalls, steady stretches, one long hold-off
   initial begin
      int  stall;
      int  phase;
      bit  steady;
      bit  squeezed;
      logic ready_next;
      stall    = 0;
      phase    = 50;
      steady   = 1'b0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if (--phase <= 0) begin
            steady = ~steady;
            phase  = $urandom_range(20, 120);
         end
         if (draining) begin
            ready_next = 1'b1;
         end else if (stall > 0) begin
            stall--;
            ready_next = 1'b0;
         end else if (!squeezed && sb.checked >= SQUEEZE_AT) begin
            squeezed   = 1'b1;
            stall      = SQUEEZE_LEN;
            ready_next = 1'b0;
         end else if (steady) begin
            ready_next = 1'b1;
         end else begin
            ready_next = $urandom_range(0, 3) != 0;
            if (!ready_next)
               stall = pick_gap() - 1;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      int directed;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_string("\\n\\t\\b\\r\\f\\\\\\777\\1\\n\\77A\\5");
      send_word(8'h00, 1'b1);
      send_string("\\");
      send_word(8'hA5, 1'b1);
      directed = words_sent;

      while (words_sent < directed + RANDOM_WORDS)
         send_token();
      send_word(8'h00, 1'b1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      draining = 1'b1;
      while (sb.due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d words in (%0d directed), %0d words out, %0d string ends",
               words_sent, directed, sb.checked, sb.terminators);
      if (sb.mismatches == 0 && sb.due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
